// ===== design/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the sharpening block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");
// Implication that is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lapsh_pkg.sv =====
// lapsh_pkg: constants, types and per-channel arithmetic of the RGB sharpening block.
// No dependencies; used by every module of the block but lapsh_ram.
package lapsh_pkg;

   // Line buffer geometry.
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WEFF_W    = COL_W + 1;

   // Pixel layout: red in the top byte, blue in the bottom byte.
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;
   localparam int PIX_W    = CHAN_W * NUM_CHAN;
   localparam int CHAN_RED   = 2;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 0;
   localparam int CHAN_MAX   = 255;

   // Register field widths and limits.
   localparam int WIDTH_REG_W    = 12;
   localparam int HEIGHT_REG_W   = 13;
   localparam int STRENGTH_W     = 10;
   localparam int WCMP_W         = (WEFF_W > WIDTH_REG_W) ? WEFF_W : WIDTH_REG_W;
   localparam int WIDTH_MIN      = 3;
   localparam int HEIGHT_MIN     = 3;
   localparam int HEIGHT_MAX     = 4096;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;
   localparam int STRENGTH_RESET = 128;

   // Row counter saturates at its full range.
   localparam int ROW_W = 13;

   // Filter arithmetic widths.
   localparam int DIFF_W = 11;
   localparam int PROD_W = DIFF_W + STRENGTH_W;
   localparam int FRAC_W = 8;
   localparam int QUOT_W = PROD_W - FRAC_W;
   localparam int SUM_W  = QUOT_W + 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_STRENGTH     = 2'd2
   } csr_index_type;

   // Raster position of the beat being accepted.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             emit;
      logic             last;
      logic             interior;
   } pos_type;

   // One channel of a packed pixel.
   function automatic logic [CHAN_W-1:0] chan_of(input logic [PIX_W-1:0] pix,
                                                  input int unsigned     idx);
      return pix[idx*CHAN_W +: CHAN_W];
   endfunction

   // Four times the center minus its four neighbours: 4*c - up - down - left - right.
   function automatic logic signed [DIFF_W-1:0] lap_diff(input logic [CHAN_W-1:0] c,
                                                         input logic [CHAN_W-1:0] up,
                                                         input logic [CHAN_W-1:0] dn,
                                                         input logic [CHAN_W-1:0] lf,
                                                         input logic [CHAN_W-1:0] rt);
      logic [DIFF_W-1:0] acc;
      // The true value stays within the signed range, so wrapping is harmless.
      acc = (DIFF_W'(c) << 2) - DIFF_W'(up) - DIFF_W'(dn) - DIFF_W'(lf) - DIFF_W'(rt);
      return $signed(acc);
   endfunction

   // Center plus the diff scaled by Q2.8 strength, truncated toward zero, clamped.
   function automatic logic [CHAN_W-1:0] lap_scale(input logic [CHAN_W-1:0]        c,
                                                   input logic signed [DIFF_W-1:0] diff,
                                                   input logic [STRENGTH_W-1:0]    strength);
      logic [DIFF_W-1:0]        mag;
      logic [PROD_W-1:0]        prod;
      logic [QUOT_W-1:0]        quot;
      logic signed [SUM_W-1:0]  sum;
      logic [CHAN_W-1:0]        res;
      mag  = diff[DIFF_W-1] ? DIFF_W'(~diff + DIFF_W'(1)) : diff;
      prod = PROD_W'(mag) * PROD_W'(strength);
      quot = prod[PROD_W-1:FRAC_W];
      if (diff[DIFF_W-1]) begin
         sum = $signed(SUM_W'(c)) - $signed(SUM_W'(quot));
      end else begin
         sum = $signed(SUM_W'(c)) + $signed(SUM_W'(quot));
      end
      if (sum < 0) begin
         res = '0;
      end else if (sum > $signed(SUM_W'(CHAN_MAX))) begin
         res = CHAN_W'(CHAN_MAX);
      end else begin
         res = sum[CHAN_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== design/rgb_laplacian_sharpen_3x3.sv =====
// RGB 3x3 Laplacian sharpening filter for a raster pixel stream. The block takes one
// pixel per clock and sustains that rate with back-to-back beats unless the result
// side stalls; the figure is set by the two line-buffer RAMs, each doing one read and
// one write per clock. In stream terms a result belongs to the pixel one line plus one
// pixel earlier, so the host sends width+1 filler beats after each frame to flush it.
// Border pixels pass through unchanged; the final pixel of a frame carries frame_end.
// Line buffers need no clearing after reset. The user writes width, height and
// strength over APB only while the block is idle; the block does not enforce it.
// Depends on lapsh_pkg, lapsh_csr, lapsh_raster, lapsh_ram and assert_macros.svh.
`include "assert_macros.svh"

module rgb_laplacian_sharpen_3x3 (
   input  logic                             clock,
   input  logic                             reset,
   // Pixel input channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lapsh_pkg::CHAN_W-1:0]     req_red_in,
   input  logic [lapsh_pkg::CHAN_W-1:0]     req_green_in,
   input  logic [lapsh_pkg::CHAN_W-1:0]     req_blue_in,
   input  logic                             req_filler,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lapsh_pkg::CHAN_W-1:0]     rsp_red_out,
   output logic [lapsh_pkg::CHAN_W-1:0]     rsp_green_out,
   output logic [lapsh_pkg::CHAN_W-1:0]     rsp_blue_out,
   output logic                             rsp_frame_end,
   // Configuration port.
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lapsh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lapsh_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lapsh_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import lapsh_pkg::*;

   logic [WEFF_W-1:0]       width_eff;
   logic [HEIGHT_REG_W-1:0] height_eff;
   logic [STRENGTH_W-1:0]   strength;
   pos_type                 pos;
   logic                    accept;
   logic [PIX_W-1:0]        pix_acc;
   logic [PIX_W-1:0]        mid_rdata;
   logic [PIX_W-1:0]        abv_rdata;
   logic [PIX_W-1:0]        above_pix;

   // Flow control.
   logic out_free, s2_move, s2_free, s1_move;

   // Stage 1: beat waiting for its line-buffer reads.
   logic               s1_valid_ff,    s1_valid_in;
   logic [COL_W-1:0]   s1_col_ff,      s1_col_in;
   logic [PIX_W-1:0]   s1_pix_ff,      s1_pix_in;
   logic               s1_emit_ff,     s1_emit_in;
   logic               s1_last_ff,     s1_last_in;
   logic               s1_interior_ff, s1_interior_in;
   logic               fwd_ff,         fwd_in;
   logic [PIX_W-1:0]   fwd_pix_ff,     fwd_pix_in;

   // Window taps that the filter reads.
   logic [PIX_W-1:0]   win_up_ff, win_up_in;
   logic [PIX_W-1:0]   win_c_ff,  win_c_in;
   logic [PIX_W-1:0]   win_dn_ff, win_dn_in;
   logic [PIX_W-1:0]   win_l_ff,  win_l_in;

   // Stage 2: center pixel and per-channel Laplacian difference.
   logic                     s2_valid_ff,    s2_valid_in;
   logic                     s2_emit_ff,     s2_emit_in;
   logic                     s2_last_ff,     s2_last_in;
   logic                     s2_interior_ff, s2_interior_in;
   logic [PIX_W-1:0]         s2_center_ff,   s2_center_in;
   logic signed [DIFF_W-1:0] s2_diff_ff [NUM_CHAN];
   logic signed [DIFF_W-1:0] s2_diff_in [NUM_CHAN];

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pix_ff,   rsp_pix_in;
   logic               rsp_last_ff,  rsp_last_in;

   lapsh_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .strength   (strength)
   );

   lapsh_raster u_raster (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .pos        (pos)
   );

   // Each stage moves when the one after it is free; a beat with no result drops out at stage 2.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && (out_free || !s2_emit_ff);
   assign s2_free   = !s2_valid_ff || s2_move;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign accept    = req_valid && req_ready;

   // A filler beat enters the buffers as a black pixel.
   assign pix_acc = req_filler ? '0 : {req_red_in, req_green_in, req_blue_in};

   // Middle line: read old entry and store the new pixel in the accept cycle.
   lapsh_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_middle (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos.col),
      .wr_data (pix_acc),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (mid_rdata)
   );

   // Upper line: takes the old middle entry once stage 1 moves on.
   lapsh_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rdata),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (abv_rdata)
   );

   // When two beats in a row share a column (right after a frame end), the
   // upper-line write lands on the same edge as the read, so forward it.
   assign above_pix = fwd_ff ? fwd_pix_ff : abv_rdata;

   // Stage 1 next state.
   always_comb begin
      s1_valid_in    = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_col_in      = s1_col_ff;
      s1_pix_in      = s1_pix_ff;
      s1_emit_in     = s1_emit_ff;
      s1_last_in     = s1_last_ff;
      s1_interior_in = s1_interior_ff;
      fwd_in         = fwd_ff;
      fwd_pix_in     = fwd_pix_ff;
      if (accept) begin
         s1_col_in      = pos.col;
         s1_pix_in      = pix_acc;
         s1_emit_in     = pos.emit;
         s1_last_in     = pos.last;
         s1_interior_in = pos.interior;
         fwd_in         = s1_move && (pos.col == s1_col_ff);
         fwd_pix_in     = mid_rdata;
      end else if (s1_move) begin
         fwd_in         = 1'b0;
      end
   end

   // Window shift: right column moves to center, new column comes from the buffers.
   always_comb begin
      win_up_in = win_up_ff;
      win_c_in  = win_c_ff;
      win_dn_in = win_dn_ff;
      win_l_in  = win_l_ff;
      if (s1_move) begin
         win_l_in  = win_c_ff;
         win_up_in = above_pix;
         win_c_in  = mid_rdata;
         win_dn_in = s1_pix_ff;
      end
   end

   // Stage 2 next state: Laplacian difference per channel.
   always_comb begin
      s2_valid_in    = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      s2_emit_in     = s2_emit_ff;
      s2_last_in     = s2_last_ff;
      s2_interior_in = s2_interior_ff;
      s2_center_in   = s2_center_ff;
      for (int k = 0; k < NUM_CHAN; k++) begin
         s2_diff_in[k] = s2_diff_ff[k];
      end
      if (s1_move) begin
         s2_emit_in     = s1_emit_ff;
         s2_last_in     = s1_last_ff;
         s2_interior_in = s1_interior_ff;
         s2_center_in   = win_c_ff;
         for (int k = 0; k < NUM_CHAN; k++) begin
            s2_diff_in[k] = lap_diff(chan_of(win_c_ff, k), chan_of(win_up_ff, k),
                                     chan_of(win_dn_ff, k), chan_of(win_l_ff, k),
                                     chan_of(mid_rdata, k));
         end
      end
   end

   // Result: scale and clamp interior pixels, pass border pixels through.
   always_comb begin
      rsp_valid_in = (s2_move && s2_emit_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      if (s2_move && s2_emit_ff) begin
         rsp_last_in = s2_last_ff;
         for (int k = 0; k < NUM_CHAN; k++) begin
            if (s2_interior_ff) begin
               rsp_pix_in[k*CHAN_W +: CHAN_W] =
                  lap_scale(chan_of(s2_center_ff, k), s2_diff_ff[k], strength);
            end else begin
               rsp_pix_in[k*CHAN_W +: CHAN_W] = chan_of(s2_center_ff, k);
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         win_up_ff    <= '0;
         win_c_ff     <= '0;
         win_dn_ff    <= '0;
         win_l_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         win_up_ff    <= win_up_in;
         win_c_ff     <= win_c_in;
         win_dn_ff    <= win_dn_in;
         win_l_ff     <= win_l_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_col_ff      <= s1_col_in;
      s1_pix_ff      <= s1_pix_in;
      s1_emit_ff     <= s1_emit_in;
      s1_last_ff     <= s1_last_in;
      s1_interior_ff <= s1_interior_in;
      fwd_pix_ff     <= fwd_pix_in;
      s2_emit_ff     <= s2_emit_in;
      s2_last_ff     <= s2_last_in;
      s2_interior_ff <= s2_interior_in;
      s2_center_ff   <= s2_center_in;
      for (int k = 0; k < NUM_CHAN; k++) begin
         s2_diff_ff[k] <= s2_diff_in[k];
      end
      rsp_pix_ff     <= rsp_pix_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = chan_of(rsp_pix_ff, CHAN_RED);
   assign rsp_green_out = chan_of(rsp_pix_ff, CHAN_GREEN);
   assign rsp_blue_out  = chan_of(rsp_pix_ff, CHAN_BLUE);
   assign rsp_frame_end = rsp_last_ff;

   // Input backpressure only comes from a full pipeline behind a stalled result.
   `ASSERT_IMPLIES(a_ready_only_when_full, clock, reset, !req_ready, s1_valid_ff && s2_valid_ff && rsp_valid_ff)
   // Forwarded upper-line data always has a beat in stage 1 to serve.
   `ASSERT_IMPLIES(a_fwd_has_beat, clock, reset, fwd_ff, s1_valid_ff)
   // Interior pixels always produce a result.
   `ASSERT_IMPLIES(a_interior_emits, clock, reset, s2_valid_ff && s2_interior_ff, s2_emit_ff)
   // After the frame's final beat the next beat is at the top of a new frame.
   `ASSERT_NEXT(a_frame_restart, clock, reset, accept && pos.last, !pos.emit && !pos.last)

endmodule

// ===== design/lapsh_ram.sv =====
// lapsh_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the line buffers of the sharpening block.
module lapsh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when both ports hit the same entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lapsh_csr.sv =====
// lapsh_csr: APB register file for frame width, frame height and strength.
// Depends on lapsh_pkg; feeds clamped geometry to the raster counter.
module lapsh_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lapsh_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lapsh_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lapsh_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready,
   output logic [lapsh_pkg::WEFF_W-1:0]         width_eff,
   output logic [lapsh_pkg::HEIGHT_REG_W-1:0]   height_eff,
   output logic [lapsh_pkg::STRENGTH_W-1:0]     strength
);
   import lapsh_pkg::*;

   logic [WIDTH_REG_W-1:0]  image_width_ff,  image_width_in;
   logic [HEIGHT_REG_W-1:0] image_height_ff, image_height_in;
   logic [STRENGTH_W-1:0]   strength_ff,     strength_in;
   logic                    wr_strobe;
   csr_index_type           index;
   logic [WCMP_W-1:0]       width_ext;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;
   assign index     = csr_index_type'(paddr[3:2]);

   // Register write decode; writes beyond the list are dropped.
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      strength_in     = strength_ff;
      if (wr_strobe) begin
         case (index)
            REG_IMAGE_WIDTH:  image_width_in  = pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: image_height_in = pwdata[HEIGHT_REG_W-1:0];
            REG_STRENGTH:     strength_in     = pwdata[STRENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_REG_W'(WIDTH_RESET);
         image_height_ff <= HEIGHT_REG_W'(HEIGHT_RESET);
         strength_ff     <= STRENGTH_W'(STRENGTH_RESET);
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         strength_ff     <= strength_in;
      end
   end

   // Read mux returns the raw register contents.
   always_comb begin
      case (index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(image_height_ff);
         REG_STRENGTH:     prdata = CSR_DATA_W'(strength_ff);
         default:          prdata = '0;
      endcase
   end

   // Geometry used by the datapath is clamped to the supported range.
   always_comb begin
      width_ext = WCMP_W'(image_width_ff);
      if (width_ext < WCMP_W'(WIDTH_MIN)) begin
         width_eff = WEFF_W'(WIDTH_MIN);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         width_eff = WEFF_W'(width_ext);
      end
      if (image_height_ff < HEIGHT_REG_W'(HEIGHT_MIN)) begin
         height_eff = HEIGHT_REG_W'(HEIGHT_MIN);
      end else if (image_height_ff > HEIGHT_REG_W'(HEIGHT_MAX)) begin
         height_eff = HEIGHT_REG_W'(HEIGHT_MAX);
      end else begin
         height_eff = image_height_ff;
      end
   end

   assign strength = strength_ff;

endmodule

// ===== design/lapsh_raster.sv =====
// lapsh_raster: column and row counters that place each accepted beat in the frame.
// Depends on lapsh_pkg; decodes emit, frame end and interior for the datapath.
module lapsh_raster (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [lapsh_pkg::WEFF_W-1:0]       width_eff,
   input  logic [lapsh_pkg::HEIGHT_REG_W-1:0] height_eff,
   output lapsh_pkg::pos_type                 pos
);
   import lapsh_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              wrap;
   logic [COL_W-1:0]  cx;
   logic [ROW_W:0]    r_cur;
   logic [ROW_W:0]    r_next;
   logic [ROW_W:0]    h_ext;
   logic [WEFF_W-1:0] col_inc;

   // A counter left at or past a shrunk width starts the next line.
   assign wrap  = WEFF_W'(col_ff) >= width_eff;
   assign cx    = wrap ? '0 : col_ff;
   assign r_cur = (ROW_W+1)'(row_ff) + (ROW_W+1)'(wrap);
   assign h_ext = (ROW_W+1)'(height_eff);

   // Results start one line plus one pixel into the stream.
   always_comb begin
      pos.col      = cx;
      pos.emit     = (r_cur >= (ROW_W+1)'(2)) ||
                     ((r_cur == (ROW_W+1)'(1)) && (cx != '0));
      pos.last     = (cx == '0) && (r_cur >= h_ext + (ROW_W+1)'(1));
      pos.interior = (cx >= COL_W'(2)) && (r_cur >= (ROW_W+1)'(2)) &&
                     (r_cur <= h_ext - (ROW_W+1)'(1));
   end

   // Advance the raster position; the frame's final beat restarts it.
   always_comb begin
      col_inc = WEFF_W'(cx) + WEFF_W'(1);
      r_next  = r_cur;
      col_in  = col_inc[COL_W-1:0];
      if (pos.last) begin
         col_in = '0;
         r_next = '0;
      end else if (col_inc >= width_eff) begin
         col_in = '0;
         r_next = r_cur + (ROW_W+1)'(1);
      end
      if (r_next > (ROW_W+1)'({ROW_W{1'b1}})) begin
         row_in = {ROW_W{1'b1}};
      end else begin
         row_in = r_next[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== dv/sharpen_scoreboard_pkg.sv =====
// Scoreboard for the RGB 3x3 Laplacian sharpening block: a beat-level model of the
// line buffers, the window and the raster counters, plus a queue of predicted pixels.
// Depends on lapsh_pkg for widths, reset values and register indexes.
package sharpen_scoreboard_pkg;
   import lapsh_pkg::*;

   // One predicted or observed output pixel.
   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_end;
   } sharp_pixel_type;

   class sharpen_scoreboard;
      logic [PIX_W-1:0]        line_above [MAX_WIDTH];
      logic [PIX_W-1:0]        line_middle [MAX_WIDTH];
      logic [PIX_W-1:0]        window [9];
      int unsigned             col_cnt;
      int unsigned             row_cnt;
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      logic [STRENGTH_W-1:0]   strength_reg;
      sharp_pixel_type         expected_q [$];
      bit                      frame_done;
      int unsigned             mismatches;
      int unsigned             beat_count;
      int unsigned             result_count;
      int unsigned             frame_count;

      function new();
         foreach (line_above[i]) begin
            line_above[i]  = '0;
            line_middle[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         col_cnt      = 0;
         row_cnt      = 0;
         width_reg    = WIDTH_REG_W'(WIDTH_RESET);
         height_reg   = HEIGHT_REG_W'(HEIGHT_RESET);
         strength_reg = STRENGTH_W'(STRENGTH_RESET);
         frame_done   = 0;
         mismatches   = 0;
         beat_count   = 0;
         result_count = 0;
         frame_count  = 0;
      endfunction

      // Geometry as the block uses it, clamped to the supported range.
      function int unsigned cur_width();
         int unsigned w;
         w = width_reg;
         if (w < WIDTH_MIN) w = WIDTH_MIN;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned cur_height();
         int unsigned h;
         h = height_reg;
         if (h < HEIGHT_MIN) h = HEIGHT_MIN;
         if (h > HEIGHT_MAX) h = HEIGHT_MAX;
         return h;
      endfunction

      // Register write; indexes past the register list are ignored.
      function void write_reg(int unsigned idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_IMAGE_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
         else if (idx == REG_IMAGE_HEIGHT) height_reg = value[HEIGHT_REG_W-1:0];
         else if (idx == REG_STRENGTH) strength_reg = value[STRENGTH_W-1:0];
      endfunction

      // True when the next beat falls on a line at or below the frame height.
      function bit next_in_flush();
         int unsigned r;
         r = row_cnt;
         if (col_cnt >= cur_width()) r++;
         return r >= cur_height();
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Sharpen one channel of the window center: c + trunc(diff*strength/256), clamped.
      function logic [CHAN_W-1:0] sharpen(int unsigned sh);
         int c, up, dn, lf, rt, d, mag, v;
         c   = int'(window[4][sh +: CHAN_W]);
         up  = int'(window[1][sh +: CHAN_W]);
         dn  = int'(window[7][sh +: CHAN_W]);
         lf  = int'(window[3][sh +: CHAN_W]);
         rt  = int'(window[5][sh +: CHAN_W]);
         d   = 4 * c - up - dn - lf - rt;
         mag = (d < 0) ? -d : d;
         v   = (mag * int'(strength_reg)) / 256;
         v   = (d < 0) ? c - v : c + v;
         if (v < 0) v = 0;
         if (v > CHAN_MAX) v = CHAN_MAX;
         return CHAN_W'(v);
      endfunction

      // Advance the model by one accepted input beat and queue its result, if any.
      function void note_beat(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                              logic [CHAN_W-1:0] blue, logic filler);
         int unsigned      w, h, cx, r;
         logic [PIX_W-1:0] pix, above, middle, center;
         bit               emit, last, interior;
         sharp_pixel_type  px;
         w  = cur_width();
         h  = cur_height();
         cx = col_cnt;
         r  = row_cnt;
         // A column past a shrunk width starts the next line.
         if (cx >= w) begin
            cx = 0;
            r++;
         end
         pix    = filler ? '0 : {red, green, blue};
         above  = line_above[cx];
         middle = line_middle[cx];
         line_above[cx]  = middle;
         line_middle[cx] = pix;
         for (int k = 0; k < 3; k++) begin
            window[k*3]   = window[k*3+1];
            window[k*3+1] = window[k*3+2];
         end
         window[2] = above;
         window[5] = middle;
         window[8] = pix;

         emit     = (r >= 2) || (r == 1 && cx >= 1);
         last     = (cx == 0) && (r >= h + 1);
         interior = (cx >= 2) && (r >= 2) && (r <= h - 1);

         if (last) begin
            cx = 0;
            r  = 0;
         end else begin
            cx++;
            if (cx >= w) begin
               cx = 0;
               r++;
            end
         end
         if (r > 32'h1FFF) r = 32'h1FFF;
         col_cnt = cx;
         row_cnt = r;
         beat_count++;
         if (last) begin
            frame_done = 1;
            frame_count++;
         end

         if (emit) begin
            center = window[4];
            if (interior) begin
               px.red   = sharpen(CHAN_RED * CHAN_W);
               px.green = sharpen(CHAN_GREEN * CHAN_W);
               px.blue  = sharpen(CHAN_BLUE * CHAN_W);
            end else begin
               px.red   = center[CHAN_RED*CHAN_W +: CHAN_W];
               px.green = center[CHAN_GREEN*CHAN_W +: CHAN_W];
               px.blue  = center[CHAN_BLUE*CHAN_W +: CHAN_W];
            end
            px.frame_end = last;
            expected_q.push_back(px);
         end
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      // Compare one output beat against the oldest predicted pixel.
      function void check_result(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                 logic [CHAN_W-1:0] blue, logic frame_end);
         sharp_pixel_type px;
         result_count++;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing predicted (%0d,%0d,%0d end=%0d)",
                             result_count, red, green, blue, frame_end));
            return;
         end
         px = expected_q.pop_front();
         if (px.red !== red || px.green !== green || px.blue !== blue ||
             px.frame_end !== frame_end) begin
            report($sformatf("result %0d: expected (%0d,%0d,%0d end=%0d) got (%0d,%0d,%0d end=%0d)",
                             result_count, px.red, px.green, px.blue, px.frame_end,
                             red, green, blue, frame_end));
         end
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for rgb_laplacian_sharpen_3x3: drives pixel beats and APB writes,
// checks every output pixel against the scoreboard's prediction.
// Depends on lapsh_pkg, sharpen_scoreboard_pkg and the block's RTL.
module tb_top;
   import lapsh_pkg::*;
   import sharpen_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 1000000;
   localparam int unsigned RANDOM_BEATS     = 1150;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned IDLE_PCT         = 22;
   localparam int unsigned REG_UNUSED_INDEX = 3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CHAN_W-1:0]     req_red_in;
   logic [CHAN_W-1:0]     req_green_in;
   logic [CHAN_W-1:0]     req_blue_in;
   logic                  req_filler;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CHAN_W-1:0]     rsp_red_out;
   logic [CHAN_W-1:0]     rsp_green_out;
   logic [CHAN_W-1:0]     rsp_blue_out;
   logic                  rsp_frame_end;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   sharpen_scoreboard sb;
   bit                idle_on;
   int unsigned       cycles;

   rgb_laplacian_sharpen_3x3 dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_filler    (req_filler),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run stopped by the watchdog after %0d cycles.", cycles);
      $display("*** FAILED ***");
      $finish;
   end

   // Output side: check each accepted beat, then pick next cycle's ready.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result(rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end);
         end
         rsp_ready <= !(idle_on && ($urandom_range(99) < IDLE_PCT));
      end
   end

   // Send one pixel beat, with an optional random gap first.
   task automatic send_beat(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                            input logic [CHAN_W-1:0] blue, input logic filler);
      while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= red;
      req_green_in <= green;
      req_blue_in  <= blue;
      req_filler   <= filler;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(red, green, blue, filler);
   endtask

   // Hold the input until every predicted pixel is out, then let the pipeline drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, then the bus is left idle.
   task automatic write_csr(input int unsigned idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Write all three registers with random junk above the field bits.
   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned s);
      write_csr(REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_F000) | w);
      write_csr(REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_E000) | h);
      write_csr(REG_STRENGTH, ($urandom & 32'hFFFF_FC00) | s);
   endtask

   // Channel value biased toward the clamp-prone extremes.
   function automatic logic [CHAN_W-1:0] rand_level();
      case ($urandom_range(9))
         0: return '0;
         1: return CHAN_W'(CHAN_MAX);
         default: return CHAN_W'($urandom_range(CHAN_MAX));
      endcase
   endfunction

   // Stream one frame until the scoreboard sees its last pixel. Optionally stop
   // somewhere inside it, drain, and shrink the width or set the height to at most its current value.
   task automatic run_frame(input bit allow_cut);
      int   cut_at;
      int   n;
      logic fill;
      cut_at = -1;
      if (allow_cut && $urandom_range(3) == 0) begin
         cut_at = $urandom_range(sb.cur_width() * sb.cur_height(), 1);
      end
      sb.frame_done = 0;
      n = 0;
      while (!sb.frame_done) begin
         if (n == cut_at) begin
            wait_idle();
            if ($urandom_range(1) == 1 && sb.cur_width() > WIDTH_MIN) begin
               write_csr(REG_IMAGE_WIDTH, $urandom_range(sb.cur_width() - 1, WIDTH_MIN));
            end else begin
               write_csr(REG_IMAGE_HEIGHT, $urandom_range(sb.cur_height(), HEIGHT_MIN));
            end
         end
         // Mostly real pixels inside the frame and fillers in the flush, with strays.
         if (sb.next_in_flush()) fill = ($urandom_range(9) != 0);
         else fill = ($urandom_range(29) == 0);
         send_beat(rand_level(), rand_level(), rand_level(), fill);
         n++;
      end
   endtask

   initial begin
      int unsigned rand_start, w, h, s, k;
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_red_in   <= '0;
      req_green_in <= '0;
      req_blue_in  <= '0;
      req_filler   <= 1'b0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      idle_on = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame, full strength: a bright center that saturates both ways.
      // Width and height below the minimum must clamp; an unused index is ignored.
      write_csr(REG_IMAGE_WIDTH, 32'hFFFF_F000);
      write_csr(REG_IMAGE_HEIGHT, 32'd1);
      write_csr(REG_STRENGTH, 32'd1023);
      write_csr(REG_UNUSED_INDEX, $urandom);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_beat(8'd255, 8'd0, 8'd200, 1'b0);
         else send_beat(8'd0, 8'd255, 8'd90, 1'b0);
      end
      // The first flush beat carries real pixel data.
      send_beat(8'h5A, 8'hA5, 8'hFF, 1'b0);
      repeat (3) send_beat(8'hFF, 8'hFF, 8'hFF, 1'b1);
      wait_idle();

      // Zero strength, with a filler in the middle of the frame taken as black.
      write_csr(REG_STRENGTH, 32'd0);
      write_csr(REG_IMAGE_HEIGHT, 32'd3);
      write_csr(REG_IMAGE_WIDTH, 32'd3);
      for (int i = 0; i < 9; i++) begin
         send_beat(rand_level(), rand_level(), rand_level(), i == 4);
      end
      repeat (4) send_beat(rand_level(), rand_level(), rand_level(), 1'b1);
      wait_idle();

      // Random frames of small size; one stretch runs with no idling on either side.
      rand_start = sb.beat_count;
      while (sb.beat_count < rand_start + RANDOM_BEATS) begin
         idle_on = !((sb.beat_count - rand_start >= 450) &&
                     (sb.beat_count - rand_start < 750));
         k = $urandom_range(9);
         if (k == 0) w = $urandom_range(2, 0);
         else if (k == 1) w = $urandom_range(40, 17);
         else w = $urandom_range(16, 3);
         h = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 3);
         k = $urandom_range(9);
         if (k == 0) s = 0;
         else if (k == 1) s = 1023;
         else s = $urandom_range(1023);
         set_geometry(w, h, s);
         run_frame(1);
         wait_idle();
      end
      idle_on = 1;
      repeat (20) @(posedge clock);

      $display("Sent %0d pixel beats in %0d frames and checked %0d output pixels.",
               sb.beat_count, sb.frame_count, sb.result_count);
      $display("Frames up to 40 wide and 10 tall, clamped and mid-frame shrunk sizes; %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/lapsh_pkg.sv
design/lapsh_ram.sv
design/lapsh_csr.sv
design/lapsh_raster.sv
design/rgb_laplacian_sharpen_3x3.sv
dv/sharpen_scoreboard_pkg.sv
dv/tb_top.sv
